FILE: hdl/c3b_pkg.sv
package c3b_pkg;

  localparam int WORD_BITS    = 64;
  localparam int FRAC_BITS    = 47;
  localparam int MU_BITS      = 47;
  localparam int HALF_BITS    = WORD_BITS / 2;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int NUM_VALUES   = 6;
  localparam int NUM_LANE_OUT = 10;
  localparam int ROOT_STEPS   = WORD_BITS;
  localparam int RECIP_STEPS  = 2 * FRAC_BITS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t colv_t [NUM_VALUES];
  typedef word_t lout_t [NUM_LANE_OUT];

  localparam word_t MAXV  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MINV  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_Q = word_t'(1) << FRAC_BITS;

  // register index codes
  localparam logic REG_MASS_RATIO = 1'b0;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  typedef struct packed {
    logic       start;
    logic       column;
    logic [2:0] ncol;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } lane_stat_t;

  typedef struct packed {
    logic done;
    logic sat;
  } mul_stat_t;

  typedef struct packed {
    logic start;
    logic column;
  } merge_cmd_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } merge_stat_t;

  // saturating add or subtract on the signed word range
  function automatic sat_word_t sat_addsub(word_t a, word_t b, logic sub);
    logic [WORD_BITS:0] s;
    sat_word_t r;
    if (sub) begin
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    end else begin
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    end
    r.sat = s[WORD_BITS] != s[WORD_BITS-1];
    r.val = r.sat ? (s[WORD_BITS] ? MINV : MAXV) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

endpackage

FILE: hdl/c3b_mul.sv
module c3b_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  c3b_pkg::word_t                    a,
  input  c3b_pkg::word_t                    b,
  output c3b_pkg::mul_stat_t                stat,
  output c3b_pkg::word_t                    q,
  output logic [c3b_pkg::PROD_BITS-1:0]     raw
);

  localparam int W = c3b_pkg::WORD_BITS;
  localparam int H = c3b_pkg::HALF_BITS;
  localparam int P = c3b_pkg::PROD_BITS;
  localparam int F = c3b_pkg::FRAC_BITS;
  localparam int QB = P - F + 1;

  logic [W-1:0]  ma, mb;
  logic          neg;
  logic [P-1:0]  acc;
  logic [QB-1:0] qt;
  logic [2:0]    step;
  logic          running;
  logic          done;
  logic          sat;

  logic [H-1:0]  ah, bh;
  logic [W-1:0]  pp;
  logic [1:0]    hsum;
  logic [P-1:0]  pp_sh;
  logic          rnd;
  logic [QB-1:0] qsum;
  logic          sat_pos, sat_neg;

  // one 32x32 partial product per cycle
  always_comb begin
    ah   = step[1] ? ma[W-1:H] : ma[H-1:0];
    bh   = step[0] ? mb[W-1:H] : mb[H-1:0];
    pp   = ah * bh;
    hsum = {1'b0, step[1]} + {1'b0, step[0]};
    case (hsum)
      2'd0:    pp_sh = {{W{1'b0}}, pp};
      2'd1:    pp_sh = {{H{1'b0}}, pp, {H{1'b0}}};
      default: pp_sh = {pp, {W{1'b0}}};
    endcase
    rnd     = neg && (acc[F-1:0] != '0);
    qsum    = {1'b0, acc[P-1:F]} + QB'(rnd);
    sat_pos = qt[QB-1:W-1] != '0;
    sat_neg = (qt[QB-1:W] != '0) || (qt[W-1] && (qt[W-2:0] != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && !start && (step == 3'd5);
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == 3'd5) begin
          running <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[W-1] ? W'(-a) : W'(a);
      mb  <= b[W-1] ? W'(-b) : W'(b);
      neg <= a[W-1] ^ b[W-1];
      acc <= '0;
    end else if (running) begin
      if (step < 3'd4) begin
        acc <= acc + pp_sh;
      end else if (step == 3'd4) begin
        qt <= qsum;
      end else begin
        if (!neg) begin
          sat <= sat_pos;
          q   <= sat_pos ? c3b_pkg::MAXV : c3b_pkg::word_t'(qt[W-1:0]);
        end else begin
          sat <= sat_neg;
          q   <= sat_neg ? c3b_pkg::MINV : c3b_pkg::word_t'(-qt[W-1:0]);
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.sat  = sat;
  assign raw       = acc;

endmodule

FILE: hdl/c3b_lane.sv
module c3b_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  c3b_pkg::lane_cmd_t      cmd,
  input  c3b_pkg::word_t          dx,
  input  c3b_pkg::word_t          y,
  input  c3b_pkg::word_t          z,
  input  c3b_pkg::word_t          coef,
  input  c3b_pkg::word_t          coef3,
  input  c3b_pkg::colv_t          ca,
  input  c3b_pkg::colv_t          cb,
  output c3b_pkg::lane_stat_t     stat,
  output c3b_pkg::lout_t          o
);

  localparam int W  = c3b_pkg::WORD_BITS;
  localparam int P  = c3b_pkg::PROD_BITS;
  localparam int RQ = c3b_pkg::RECIP_STEPS;
  localparam logic [4:0] LAST_STATE_OP = 5'd16;
  localparam logic [6:0] LAST_ROOT     = 7'(c3b_pkg::ROOT_STEPS - 1);
  localparam logic [6:0] LAST_RECIP    = 7'(RQ - 1);

  typedef enum logic [2:0] {L_IDLE, L_SQ, L_ROOT, L_RECIP, L_MUL} lstate_t;

  lstate_t        lstate;
  logic [4:0]     k;
  logic           waiting;
  logic           column;
  logic [2:0]     ncol;
  logic           sat;
  logic [6:0]     cnt;
  logic [P-1:0]   n;
  logic [W:0]     rem_s;
  logic [W-1:0]   root;
  logic [W-1:0]   rem_d;
  logic [RQ-2:0]  quo;
  c3b_pkg::word_t inv, i2, i3, i5, h, t;

  logic               mstart;
  c3b_pkg::word_t     opa, opb, mq;
  c3b_pkg::mul_stat_t mstat;
  logic [P-1:0]       mraw;

  logic [W+2:0]  rem2, trial;
  logic          rge;
  logic [W:0]    rem2d;
  logic          dge;
  logic [RQ-1:0] qfin;

  c3b_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (opa),
    .b     (opb),
    .stat  (mstat),
    .q     (mq),
    .raw   (mraw)
  );

  assign mstart = ((lstate == L_SQ) || (lstate == L_MUL)) && !waiting;

  // operand selection for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    if (lstate == L_SQ) begin
      case (k[1:0])
        2'd0:    begin opa = dx; opb = dx; end
        2'd1:    begin opa = y;  opb = y;  end
        default: begin opa = z;  opb = z;  end
      endcase
    end else if (column) begin
      opa = ca[k[2:0]];
      opb = cb[k[2:0]];
    end else begin
      case (k)
        5'd0:    begin opa = inv;   opb = inv; end
        5'd1:    begin opa = i2;    opb = inv; end
        5'd2:    begin opa = i3;    opb = i2;  end
        5'd3:    begin opa = coef;  opb = i3;  end
        5'd4:    begin opa = coef3; opb = i5;  end
        5'd5:    begin opa = o[9];  opb = dx;  end
        5'd6:    begin opa = o[9];  opb = y;   end
        5'd7:    begin opa = o[9];  opb = z;   end
        5'd8:    begin opa = h;     opb = dx;  end
        5'd9:    begin opa = t;     opb = dx;  end
        5'd10:   begin opa = t;     opb = y;   end
        5'd11:   begin opa = t;     opb = z;   end
        5'd12:   begin opa = h;     opb = y;   end
        5'd13:   begin opa = t;     opb = y;   end
        5'd14:   begin opa = t;     opb = z;   end
        5'd15:   begin opa = h;     opb = z;   end
        default: begin opa = t;     opb = z;   end
      endcase
    end
  end

  // one root bit and one quotient bit per cycle
  always_comb begin
    rem2  = {rem_s, n[P-1:P-2]};
    trial = {1'b0, root, 2'b01};
    rge   = rem2 >= trial;
    rem2d = {rem_d, (cnt == 7'd0)};
    dge   = rem2d >= {1'b0, root};
    qfin  = {quo, dge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lstate  <= L_IDLE;
      waiting <= 1'b0;
      sat     <= 1'b0;
      k       <= '0;
      cnt     <= '0;
    end else begin
      case (lstate)
        L_IDLE: begin
          if (cmd.start) begin
            column  <= cmd.column;
            ncol    <= cmd.ncol;
            k       <= '0;
            waiting <= 1'b0;
            sat     <= 1'b0;
            n       <= '0;
            lstate  <= cmd.column ? L_MUL : L_SQ;
          end
        end
        L_SQ: begin
          if (mstart) waiting <= 1'b1;
          if (mstat.done) begin
            waiting <= 1'b0;
            n       <= n + mraw;
            if (k == 5'd2) begin
              lstate <= L_ROOT;
              cnt    <= '0;
              rem_s  <= '0;
              root   <= '0;
            end else begin
              k <= k + 5'd1;
            end
          end
        end
        L_ROOT: begin
          rem_s <= rge ? (W+1)'(rem2 - trial) : rem2[W:0];
          root  <= {root[W-2:0], rge};
          n     <= n << 2;
          cnt   <= (cnt == LAST_ROOT) ? 7'd0 : cnt + 7'd1;
          if (cnt == LAST_ROOT) begin
            lstate <= L_RECIP;
            rem_d  <= '0;
            quo    <= '0;
          end
        end
        L_RECIP: begin
          if (root == '0) begin
            // at a primary: reciprocal saturates
            inv    <= c3b_pkg::MAXV;
            sat    <= 1'b1;
            k      <= '0;
            lstate <= L_MUL;
          end else begin
            rem_d <= dge ? W'(rem2d - {1'b0, root}) : rem2d[W-1:0];
            quo   <= qfin[RQ-2:0];
            cnt   <= cnt + 7'd1;
            if (cnt == LAST_RECIP) begin
              if (qfin[RQ-1:W-1] != '0) begin
                inv <= c3b_pkg::MAXV;
                sat <= 1'b1;
              end else begin
                inv <= c3b_pkg::word_t'({1'b0, qfin[W-2:0]});
              end
              k      <= '0;
              lstate <= L_MUL;
            end
          end
        end
        L_MUL: begin
          if (mstart) waiting <= 1'b1;
          if (mstat.done) begin
            waiting <= 1'b0;
            sat     <= sat | mstat.sat;
            if (column) begin
              o[k[3:0]] <= mq;
              if (k == 5'(ncol) - 5'd1) lstate <= L_IDLE;
            end else begin
              case (k)
                5'd0:    i2   <= mq;
                5'd1:    i3   <= mq;
                5'd2:    i5   <= mq;
                5'd3:    o[9] <= mq;
                5'd4:    h    <= mq;
                5'd5:    o[0] <= mq;
                5'd6:    o[1] <= mq;
                5'd7:    o[2] <= mq;
                5'd8:    t    <= mq;
                5'd9:    o[3] <= mq;
                5'd10:   o[4] <= mq;
                5'd11:   o[5] <= mq;
                5'd12:   t    <= mq;
                5'd13:   o[6] <= mq;
                5'd14:   o[7] <= mq;
                5'd15:   t    <= mq;
                default: o[8] <= mq;
              endcase
              if (k == LAST_STATE_OP) lstate <= L_IDLE;
            end
            k <= k + 5'd1;
          end
        end
        default: lstate <= L_IDLE;
      endcase
    end
  end

  assign stat.busy = lstate != L_IDLE;
  assign stat.sat  = sat;

endmodule

FILE: hdl/c3b_merge.sv
module c3b_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  c3b_pkg::merge_cmd_t   cmd,
  input  c3b_pkg::colv_t        v,
  input  c3b_pkg::lout_t        la,
  input  c3b_pkg::lout_t        lb,
  output c3b_pkg::merge_stat_t  stat,
  output c3b_pkg::word_t        res [3],
  output c3b_pkg::colv_t        grad
);

  typedef enum logic [4:0] {
    S_ZERO, S_ONE, S_V0, S_V1, S_V2, S_V3, S_V4, S_V5, S_ACC, S_BASE, S_E,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8, S_B9
  } src_t;

  typedef enum logic [3:0] {
    D_ACC, D_BASE, D_E, D_R3, D_R4, D_R5, D_U0, D_U1, D_U2, D_U3, D_U4, D_U5
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic sub;
    dst_t d;
    logic last;
  } step_t;

  function automatic step_t mk(src_t a, src_t b, logic sub, dst_t d, logic last);
    step_t s;
    s.a = a; s.b = b; s.sub = sub; s.d = d; s.last = last;
    return s;
  endfunction

  // chains run left to right, one saturating add a cycle
  function automatic step_t prog(logic col, logic [4:0] idx);
    step_t s;
    s = mk(S_ZERO, S_ZERO, 1'b0, D_ACC, 1'b1);
    if (col) begin
      case (idx)
        5'd0:    s = mk(S_V4,  S_V4, 1'b0, D_E,   1'b0);
        5'd1:    s = mk(S_A0,  S_A1, 1'b0, D_ACC, 1'b0);
        5'd2:    s = mk(S_ACC, S_A2, 1'b0, D_ACC, 1'b0);
        5'd3:    s = mk(S_ACC, S_E,  1'b0, D_R3,  1'b0);
        5'd4:    s = mk(S_V3,  S_V3, 1'b0, D_E,   1'b0);
        5'd5:    s = mk(S_B0,  S_B1, 1'b0, D_ACC, 1'b0);
        5'd6:    s = mk(S_ACC, S_B2, 1'b0, D_ACC, 1'b0);
        5'd7:    s = mk(S_ACC, S_E,  1'b1, D_R4,  1'b0);
        5'd8:    s = mk(S_A3,  S_A4, 1'b0, D_ACC, 1'b0);
        default: s = mk(S_ACC, S_A5, 1'b0, D_R5,  1'b1);
      endcase
    end else begin
      case (idx)
        5'd0:    s = mk(S_V4,   S_V4, 1'b0, D_ACC,  1'b0);
        5'd1:    s = mk(S_ACC,  S_V0, 1'b0, D_ACC,  1'b0);
        5'd2:    s = mk(S_ACC,  S_A0, 1'b1, D_ACC,  1'b0);
        5'd3:    s = mk(S_ACC,  S_B0, 1'b1, D_R3,   1'b0);
        5'd4:    s = mk(S_V3,   S_V3, 1'b0, D_ACC,  1'b0);
        5'd5:    s = mk(S_V1,   S_ACC, 1'b1, D_ACC, 1'b0);
        5'd6:    s = mk(S_ACC,  S_A1, 1'b1, D_ACC,  1'b0);
        5'd7:    s = mk(S_ACC,  S_B1, 1'b1, D_R4,   1'b0);
        5'd8:    s = mk(S_ZERO, S_A2, 1'b1, D_ACC,  1'b0);
        5'd9:    s = mk(S_ACC,  S_B2, 1'b1, D_R5,   1'b0);
        5'd10:   s = mk(S_ZERO, S_A9, 1'b1, D_ACC,  1'b0);
        5'd11:   s = mk(S_ACC,  S_B9, 1'b1, D_BASE, 1'b0);
        5'd12:   s = mk(S_ONE,  S_BASE, 1'b0, D_ACC, 1'b0);
        5'd13:   s = mk(S_ACC,  S_A3, 1'b0, D_ACC,  1'b0);
        5'd14:   s = mk(S_ACC,  S_B3, 1'b0, D_U0,   1'b0);
        5'd15:   s = mk(S_A4,   S_B4, 1'b0, D_U1,   1'b0);
        5'd16:   s = mk(S_A5,   S_B5, 1'b0, D_U2,   1'b0);
        5'd17:   s = mk(S_ONE,  S_BASE, 1'b0, D_ACC, 1'b0);
        5'd18:   s = mk(S_ACC,  S_A6, 1'b0, D_ACC,  1'b0);
        5'd19:   s = mk(S_ACC,  S_B6, 1'b0, D_U3,   1'b0);
        5'd20:   s = mk(S_A7,   S_B7, 1'b0, D_U4,   1'b0);
        5'd21:   s = mk(S_BASE, S_A8, 1'b0, D_ACC,  1'b0);
        default: s = mk(S_ACC,  S_B8, 1'b0, D_U5,   1'b1);
      endcase
    end
    return s;
  endfunction

  logic           busy;
  logic           column;
  logic           sat;
  logic [4:0]     idx;
  c3b_pkg::word_t acc, base, e;

  step_t              cur;
  c3b_pkg::word_t     va, vb;
  c3b_pkg::sat_word_t sr;

  function automatic c3b_pkg::word_t pick(src_t s, c3b_pkg::colv_t vv, c3b_pkg::lout_t xa,
                                          c3b_pkg::lout_t xb, c3b_pkg::word_t ac,
                                          c3b_pkg::word_t bs, c3b_pkg::word_t ee);
    c3b_pkg::word_t r;
    case (s)
      S_ZERO:  r = '0;
      S_ONE:   r = c3b_pkg::ONE_Q;
      S_V0:    r = vv[0];
      S_V1:    r = vv[1];
      S_V2:    r = vv[2];
      S_V3:    r = vv[3];
      S_V4:    r = vv[4];
      S_V5:    r = vv[5];
      S_ACC:   r = ac;
      S_BASE:  r = bs;
      S_E:     r = ee;
      S_A0:    r = xa[0];
      S_A1:    r = xa[1];
      S_A2:    r = xa[2];
      S_A3:    r = xa[3];
      S_A4:    r = xa[4];
      S_A5:    r = xa[5];
      S_A6:    r = xa[6];
      S_A7:    r = xa[7];
      S_A8:    r = xa[8];
      S_A9:    r = xa[9];
      S_B0:    r = xb[0];
      S_B1:    r = xb[1];
      S_B2:    r = xb[2];
      S_B3:    r = xb[3];
      S_B4:    r = xb[4];
      S_B5:    r = xb[5];
      S_B6:    r = xb[6];
      S_B7:    r = xb[7];
      S_B8:    r = xb[8];
      S_B9:    r = xb[9];
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    cur = prog(column, idx);
    va  = pick(cur.a, v, la, lb, acc, base, e);
    vb  = pick(cur.b, v, la, lb, acc, base, e);
    sr  = c3b_pkg::sat_addsub(va, vb, cur.sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sat  <= 1'b0;
      idx  <= '0;
      for (int i = 0; i < c3b_pkg::NUM_VALUES; i++) grad[i] <= '0;
    end else begin
      if (cmd.start) begin
        busy   <= 1'b1;
        column <= cmd.column;
        idx    <= '0;
        sat    <= 1'b0;
      end else if (busy) begin
        sat <= sat | sr.sat;
        case (cur.d)
          D_ACC:   acc     <= sr.val;
          D_BASE:  base    <= sr.val;
          D_E:     e       <= sr.val;
          D_R3:    res[0]  <= sr.val;
          D_R4:    res[1]  <= sr.val;
          D_R5:    res[2]  <= sr.val;
          D_U0:    grad[0] <= sr.val;
          D_U1:    grad[1] <= sr.val;
          D_U2:    grad[2] <= sr.val;
          D_U3:    grad[3] <= sr.val;
          D_U4:    grad[4] <= sr.val;
          D_U5:    grad[5] <= sr.val;
          default: acc     <= sr.val;
        endcase
        if (cur.last) busy <= 1'b0;
        idx <= idx + 5'd1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.sat  = sat;

endmodule

FILE: hdl/cr3bp_state_and_stm_derivative_top.sv
// channel   | signals                                        | direction
// ----------+------------------------------------------------+----------
// item      | item_valid, item_stall, action, column_index,  | in
//           | value_0 .. value_5                             |
// result    | result_valid, result_stall, result_kind,       | out
//           | result_column, deriv_0 .. deriv_5, overflow    |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready (mass_ratio at byte address 0)          |
//
// a state word runs three squares, a 64-step square root, a 95-step reciprocal and
// 17 multiplies on the lane multiplier, then a 23-step merge; both primaries run at once
// in their own lane
// a column word runs six products on the busier lane, then 10 merge steps
// one word is worked at a time; the next word is taken while the result register waits
// rst is synchronous; it clears control, the gradient block and mass_ratio
// result_stall holds the result register and the finish step; item_stall is high while a word is at work
module cr3bp_state_and_stm_derivative_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [2:0]  column_index,
  input  logic signed [63:0] value_0,
  input  logic signed [63:0] value_1,
  input  logic signed [63:0] value_2,
  input  logic signed [63:0] value_3,
  input  logic signed [63:0] value_4,
  input  logic signed [63:0] value_5,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [2:0]  result_column,
  output logic signed [63:0] deriv_0,
  output logic signed [63:0] deriv_1,
  output logic signed [63:0] deriv_2,
  output logic signed [63:0] deriv_3,
  output logic signed [63:0] deriv_4,
  output logic signed [63:0] deriv_5,
  output logic        overflow
);

  localparam int MU = c3b_pkg::MU_BITS;

  typedef enum logic [2:0] {T_IDLE, T_PREP, T_LSTART, T_LANES, T_MSTART, T_MERGE, T_FIN} tstate_t;

  tstate_t           state;
  logic [MU-1:0]     mass_ratio;
  logic              kind;
  logic [2:0]        col;
  c3b_pkg::colv_t    v;
  c3b_pkg::word_t    dx1, dx2;
  logic              pre_sat;
  logic              grad_ovf;

  c3b_pkg::word_t      mu, om, mu3, om3;
  c3b_pkg::sat_word_t  sa1, sa2;
  c3b_pkg::lane_cmd_t  lcmd0, lcmd1;
  c3b_pkg::lane_stat_t lstat0, lstat1;
  c3b_pkg::lout_t      lo0, lo1;
  c3b_pkg::colv_t      ca0, cb0, ca1, cb1;
  c3b_pkg::merge_cmd_t mcmd;
  c3b_pkg::merge_stat_t mstat;
  c3b_pkg::word_t      mres [3];
  c3b_pkg::colv_t      grad;
  logic                total_sat;
  logic                take;
  logic                cfg_wr;

  // config port, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == c3b_pkg::REG_MASS_RATIO) ? 64'(mass_ratio) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_ratio <= '0;
    end else if (cfg_wr && (paddr[3] == c3b_pkg::REG_MASS_RATIO)) begin
      mass_ratio <= pwdata[MU-1:0];
    end
  end

  // mu and 1-mu with their triples; dx to each primary
  always_comb begin
    mu  = c3b_pkg::word_t'({{(c3b_pkg::WORD_BITS-MU){1'b0}}, mass_ratio});
    om  = c3b_pkg::ONE_Q - mu;
    mu3 = (mu <<< 1) + mu;
    om3 = (om <<< 1) + om;
    sa1 = c3b_pkg::sat_addsub(v[0], mu, 1'b0);
    sa2 = c3b_pkg::sat_addsub(v[0], om, 1'b1);
  end

  // column words: lane 0 takes rows three and five, lane 1 takes row four
  always_comb begin
    ca0[0] = grad[0]; cb0[0] = v[0];
    ca0[1] = grad[1]; cb0[1] = v[1];
    ca0[2] = grad[2]; cb0[2] = v[2];
    ca0[3] = grad[2]; cb0[3] = v[0];
    ca0[4] = grad[4]; cb0[4] = v[1];
    ca0[5] = grad[5]; cb0[5] = v[2];
    ca1[0] = grad[1]; cb1[0] = v[0];
    ca1[1] = grad[3]; cb1[1] = v[1];
    ca1[2] = grad[4]; cb1[2] = v[2];
    ca1[3] = '0;      cb1[3] = '0;
    ca1[4] = '0;      cb1[4] = '0;
    ca1[5] = '0;      cb1[5] = '0;
  end

  assign lcmd0.start  = state == T_LSTART;
  assign lcmd0.column = kind;
  assign lcmd0.ncol   = 3'd6;
  assign lcmd1.start  = state == T_LSTART;
  assign lcmd1.column = kind;
  assign lcmd1.ncol   = 3'd3;
  assign mcmd.start   = state == T_MSTART;
  assign mcmd.column  = kind;

  // lane 0 works on the primary of mass 1-mu, lane 1 on the primary of mass mu
  c3b_lane u_lane0 (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lcmd0),
    .dx    (dx1),
    .y     (v[1]),
    .z     (v[2]),
    .coef  (om),
    .coef3 (om3),
    .ca    (ca0),
    .cb    (cb0),
    .stat  (lstat0),
    .o     (lo0)
  );

  c3b_lane u_lane1 (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lcmd1),
    .dx    (dx2),
    .y     (v[1]),
    .z     (v[2]),
    .coef  (mu),
    .coef3 (mu3),
    .ca    (ca1),
    .cb    (cb1),
    .stat  (lstat1),
    .o     (lo1)
  );

  // merge holds the latched gradient block
  c3b_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mcmd),
    .v    (v),
    .la   (lo0),
    .lb   (lo1),
    .stat (mstat),
    .res  (mres),
    .grad (grad)
  );

  assign item_stall = state != T_IDLE;
  assign take       = item_valid && !item_stall;
  assign total_sat  = pre_sat | lstat0.sat | lstat1.sat | mstat.sat | (kind & grad_ovf);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result_valid <= 1'b0;
      grad_ovf     <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != T_FIN)) result_valid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (take) state <= action ? T_LSTART : T_PREP;
        end
        T_PREP:   state <= T_LSTART;
        T_LSTART: state <= T_LANES;
        T_LANES: begin
          if (!lstat0.busy && !lstat1.busy) state <= T_MSTART;
        end
        T_MSTART: state <= T_MERGE;
        T_MERGE: begin
          if (!mstat.busy) state <= T_FIN;
        end
        T_FIN: begin
          // load the result register once it is free
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            if (!kind) grad_ovf <= total_sat;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // word payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      kind    <= action;
      col     <= column_index;
      v[0]    <= value_0;
      v[1]    <= value_1;
      v[2]    <= value_2;
      v[3]    <= value_3;
      v[4]    <= value_4;
      v[5]    <= value_5;
      pre_sat <= 1'b0;
    end
    if (state == T_PREP) begin
      dx1     <= sa1.val;
      dx2     <= sa2.val;
      pre_sat <= sa1.sat | sa2.sat;
    end
    if ((state == T_FIN) && (!result_valid || !result_stall)) begin
      result_kind   <= kind;
      result_column <= kind ? col : 3'd0;
      deriv_0       <= v[3];
      deriv_1       <= v[4];
      deriv_2       <= v[5];
      deriv_3       <= mres[0];
      deriv_4       <= mres[1];
      deriv_5       <= mres[2];
      overflow      <= total_sat;
    end
  end

  // lanes and merge never run together
  assert property (@(posedge clk) disable iff (rst)
    !(mstat.busy && (lstat0.busy || lstat1.busy)))
    else $error("merge busy while a lane is busy");

  // both lanes start together on every word
  assert property (@(posedge clk) disable iff (rst)
    (state == T_LSTART) |=> (lstat0.busy && lstat1.busy))
    else $error("lane did not start");

  // a taken word blocks the input until it is finished
  assert property (@(posedge clk) disable iff (rst)
    take |=> item_stall)
    else $error("input open while a word is at work");

  // a result is loaded only from the finish step
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == T_FIN))
    else $error("result loaded outside the finish step");

endmodule

FILE: tb/tb.sv
module tb;

  // one input word as the driver presents it
  typedef struct {
    logic           action;
    logic [2:0]     column_index;
    c3b_pkg::word_t value [c3b_pkg::NUM_VALUES];
  } item_t;

  // one result word as the monitor expects it
  typedef struct {
    logic           kind;
    logic [2:0]     column;
    c3b_pkg::word_t deriv [c3b_pkg::NUM_VALUES];
    logic           ovf;
  } deriv_t;

  localparam logic ACT_STATE  = 1'b0;
  localparam logic ACT_COLUMN = 1'b1;
  localparam logic [46:0] MU_MAX  = {47{1'b1}};
  localparam logic [46:0] MU_HALF = 47'd1 << 46;
  localparam logic [46:0] MU_EM   = 47'd1710043000000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;
  logic item_valid, item_stall, action;
  logic [2:0] column_index;
  c3b_pkg::word_t value_0, value_1, value_2, value_3, value_4, value_5;
  logic result_valid, result_stall, result_kind, overflow;
  logic [2:0] result_column;
  c3b_pkg::word_t deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5;

  cr3bp_state_and_stm_derivative_top i_dut (.*);

  // predictor state: our own copy of the mass ratio and the gradient block
  c3b_pkg::word_t mu_q;
  c3b_pkg::word_t grad [c3b_pkg::NUM_VALUES];
  logic  grad_ovf;
  logic  sat_hit;

  item_t  pending [$];
  deriv_t expected [$];
  int     errors;
  bit     took;
  int     tx_gap, rx_gap, hold_cnt;
  bit     hold_req, quiet;

  // ---------------------------------------------------------------
  // fixed point primitives, the arithmetic ones saturating and flagging
  // ---------------------------------------------------------------
  function automatic c3b_pkg::word_t add_sat(c3b_pkg::word_t a, c3b_pkg::word_t b);
    logic signed [c3b_pkg::WORD_BITS:0] s;
    s = {a[c3b_pkg::WORD_BITS-1], a} + {b[c3b_pkg::WORD_BITS-1], b};
    if (s[c3b_pkg::WORD_BITS] != s[c3b_pkg::WORD_BITS-1]) begin
      sat_hit = 1'b1;
      return s[c3b_pkg::WORD_BITS] ? c3b_pkg::MINV : c3b_pkg::MAXV;
    end
    return s[c3b_pkg::WORD_BITS-1:0];
  endfunction

  function automatic c3b_pkg::word_t sub_sat(c3b_pkg::word_t a, c3b_pkg::word_t b);
    logic signed [c3b_pkg::WORD_BITS:0] s;
    s = {a[c3b_pkg::WORD_BITS-1], a} - {b[c3b_pkg::WORD_BITS-1], b};
    if (s[c3b_pkg::WORD_BITS] != s[c3b_pkg::WORD_BITS-1]) begin
      sat_hit = 1'b1;
      return s[c3b_pkg::WORD_BITS] ? c3b_pkg::MINV : c3b_pkg::MAXV;
    end
    return s[c3b_pkg::WORD_BITS-1:0];
  endfunction

  // exact product, floored to the fraction grid
  function automatic c3b_pkg::word_t mul_sat(c3b_pkg::word_t a, c3b_pkg::word_t b);
    logic signed [c3b_pkg::PROD_BITS-1:0] p, q;
    p = a;
    q = b;
    p = p * q;
    q = p >>> c3b_pkg::FRAC_BITS;
    if (q[c3b_pkg::PROD_BITS-1:c3b_pkg::WORD_BITS-1] !=
        {(c3b_pkg::PROD_BITS-c3b_pkg::WORD_BITS+1){q[c3b_pkg::WORD_BITS-1]}}) begin
      sat_hit = 1'b1;
      return q[c3b_pkg::PROD_BITS-1] ? c3b_pkg::MINV : c3b_pkg::MAXV;
    end
    return q[c3b_pkg::WORD_BITS-1:0];
  endfunction

  function automatic logic [63:0] magnitude(c3b_pkg::word_t a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [63:0] distance(c3b_pkg::word_t a, c3b_pkg::word_t b,
                                           c3b_pkg::word_t c);
    logic [127:0] n, ma, mb, mc, t;
    logic [63:0] r;
    ma = magnitude(a);
    mb = magnitude(b);
    mc = magnitude(c);
    n = ma * ma + mb * mb + mc * mc;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = {64'd0, r | (64'd1 << i)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  function automatic c3b_pkg::word_t inverse(logic [63:0] d);
    logic [127:0] q;
    if (d == 0) begin
      sat_hit = 1'b1;
      return c3b_pkg::MAXV;
    end
    q = (128'd1 << (2 * c3b_pkg::FRAC_BITS)) / {64'd0, d};
    if (q > {64'd0, c3b_pkg::MAXV}) begin
      sat_hit = 1'b1;
      return c3b_pkg::MAXV;
    end
    return q[63:0];
  endfunction

  function automatic c3b_pkg::word_t gterm(c3b_pkg::word_t h, c3b_pkg::word_t a,
                                           c3b_pkg::word_t b);
    return mul_sat(mul_sat(h, a), b);
  endfunction

  // expected result of one accepted word; updates the gradient block on state words
  function automatic deriv_t derive(item_t it);
    deriv_t r;
    c3b_pkg::word_t v [c3b_pkg::NUM_VALUES];
    c3b_pkg::word_t om, dx1, dx2, i1, i2, i1s, i2s, i1c, i2c, i1f, i2f, g1, g2, h1, h2, base;
    v = it.value;
    sat_hit = 1'b0;
    r.kind = it.action;
    r.deriv[0] = v[3];
    r.deriv[1] = v[4];
    r.deriv[2] = v[5];
    if (it.action == ACT_STATE) begin
      om  = c3b_pkg::ONE_Q - mu_q;
      dx1 = add_sat(v[0], mu_q);
      dx2 = add_sat(v[0], mu_q - c3b_pkg::ONE_Q);
      i1  = inverse(distance(dx1, v[1], v[2]));
      i2  = inverse(distance(dx2, v[1], v[2]));
      i1s = mul_sat(i1, i1);
      i2s = mul_sat(i2, i2);
      i1c = mul_sat(i1s, i1);
      i2c = mul_sat(i2s, i2);
      i1f = mul_sat(i1c, i1s);
      i2f = mul_sat(i2c, i2s);
      g1  = mul_sat(om, i1c);
      g2  = mul_sat(mu_q, i2c);
      h1  = mul_sat(3 * om, i1f);
      h2  = mul_sat(3 * mu_q, i2f);
      base = sub_sat(sub_sat(0, g1), g2);
      r.deriv[3] = sub_sat(sub_sat(add_sat(add_sat(v[4], v[4]), v[0]),
                   mul_sat(g1, dx1)), mul_sat(g2, dx2));
      r.deriv[4] = sub_sat(sub_sat(sub_sat(v[1], add_sat(v[3], v[3])),
                   mul_sat(g1, v[1])), mul_sat(g2, v[1]));
      r.deriv[5] = sub_sat(sub_sat(0, mul_sat(g1, v[2])), mul_sat(g2, v[2]));
      grad[0] = add_sat(add_sat(add_sat(c3b_pkg::ONE_Q, base), gterm(h1, dx1, dx1)),
                gterm(h2, dx2, dx2));
      grad[1] = add_sat(gterm(h1, dx1, v[1]), gterm(h2, dx2, v[1]));
      grad[2] = add_sat(gterm(h1, dx1, v[2]), gterm(h2, dx2, v[2]));
      grad[3] = add_sat(add_sat(add_sat(c3b_pkg::ONE_Q, base), gterm(h1, v[1], v[1])),
                gterm(h2, v[1], v[1]));
      grad[4] = add_sat(gterm(h1, v[1], v[2]), gterm(h2, v[1], v[2]));
      grad[5] = add_sat(add_sat(base, gterm(h1, v[2], v[2])), gterm(h2, v[2], v[2]));
      grad_ovf = sat_hit;
      r.column = 3'd0;
    end else begin
      r.deriv[3] = add_sat(add_sat(add_sat(mul_sat(grad[0], v[0]), mul_sat(grad[1], v[1])),
                   mul_sat(grad[2], v[2])), add_sat(v[4], v[4]));
      r.deriv[4] = sub_sat(add_sat(add_sat(mul_sat(grad[1], v[0]), mul_sat(grad[3], v[1])),
                   mul_sat(grad[4], v[2])), add_sat(v[3], v[3]));
      r.deriv[5] = add_sat(add_sat(mul_sat(grad[2], v[0]), mul_sat(grad[4], v[1])),
                   mul_sat(grad[5], v[2]));
      if (grad_ovf) sat_hit = 1'b1;
      r.column = it.column_index;
    end
    r.ovf = sat_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("tb failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------
  // driver: presents queued words at the falling edge
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      // a stalled word stays put
      if (!(item_valid && !took)) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          item_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          action       <= pending[0].action;
          column_index <= pending[0].column_index;
          value_0      <= pending[0].value[0];
          value_1      <= pending[0].value[1];
          value_2      <= pending[0].value[2];
          value_3      <= pending[0].value[3];
          value_4      <= pending[0].value[4];
          value_5      <= pending[0].value[5];
          item_valid   <= 1'b1;
          tx_gap = gap_len();
        end else begin
          item_valid <= 1'b0;
        end
      end
      took = 1'b0;
    end
  end

  // accepted word: predict from the head of the pending queue
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      expected.insert(expected.size(), derive(pending.pop_front()));
      took = 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // receiver: random stalls plus one long hold on request
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        result_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        rx_gap = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: compare each result word with the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    deriv_t e;
    c3b_pkg::word_t got [c3b_pkg::NUM_VALUES];
    if (!rst && result_valid && !result_stall) begin
      got = '{deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5};
      if (expected.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected.pop_front();
        if (result_kind !== e.kind) begin
          $error("result_kind: expected %0d got %0d", e.kind, result_kind);
          errors++;
        end
        if (result_column !== e.column) begin
          $error("result_column: expected %0d got %0d", e.column, result_column);
          errors++;
        end
        for (int i = 0; i < c3b_pkg::NUM_VALUES; i++) begin
          if (got[i] !== e.deriv[i]) begin
            $error("deriv_%0d: expected %h got %h", i, e.deriv[i], got[i]);
            errors++;
          end
        end
        if (overflow !== e.ovf) begin
          $error("overflow: expected %0d got %0d", e.ovf, overflow);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  // register write over the config port, only while the block is idle
  task automatic write_mass_ratio(logic [46:0] mu);
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= 4'(8 * c3b_pkg::REG_MASS_RATIO);
    pwdata <= {17'd0, mu};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mu_q = {17'd0, mu};
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || item_valid || expected.size() > 0) @(posedge clk);
  endtask

  function automatic c3b_pkg::word_t rand_full();
    return {$urandom, $urandom};
  endfunction

  // signed value within about +-2.0
  function automatic c3b_pkg::word_t rand_near();
    logic [48:0] r;
    r = {$urandom, $urandom};
    return {{15{r[48]}}, r};
  endfunction

  function automatic c3b_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: return c3b_pkg::MAXV;
      1: return c3b_pkg::MINV;
      2, 3: return rand_full();
      default: return rand_near();
    endcase
  endfunction

  task automatic add_item(logic act, logic [2:0] col, c3b_pkg::word_t v0,
                          c3b_pkg::word_t v1, c3b_pkg::word_t v2, c3b_pkg::word_t v3,
                          c3b_pkg::word_t v4, c3b_pkg::word_t v5);
    item_t it;
    it.action       = act;
    it.column_index = col;
    it.value        = '{v0, v1, v2, v3, v4, v5};
    pending.insert(pending.size(), it);
  endtask

  // a state word near the primaries followed by its six columns
  task automatic add_sequence();
    c3b_pkg::word_t x;
    x = rand_near();
    if ($urandom_range(0, 9) == 0) x = -mu_q + c3b_pkg::word_t'($urandom_range(0, 3));
    add_item(ACT_STATE, 3'($urandom), x, rand_near(), rand_near(),
             rand_near(), rand_near(), rand_near());
    for (int c = 0; c < c3b_pkg::NUM_VALUES; c++)
      add_item(ACT_COLUMN, 3'(c), rand_word(), rand_word(), rand_word(),
               rand_word(), rand_word(), rand_word());
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    logic [46:0] mu_set [5];
    int n;
    errors = 0;
    took = 1'b0;
    tx_gap = 0;
    rx_gap = 0;
    hold_cnt = 0;
    hold_req = 1'b0;
    quiet = 1'b0;
    mu_q = '0;
    grad = '{default: '0};
    grad_ovf = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    action = ACT_STATE;
    column_index = '0;
    {value_0, value_1, value_2, value_3, value_4, value_5} = '0;
    result_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, mass ratio at reset value zero: columns before any state word
    add_item(ACT_COLUMN, 3'd0, c3b_pkg::ONE_Q, c3b_pkg::ONE_Q, c3b_pkg::ONE_Q,
             c3b_pkg::ONE_Q, c3b_pkg::ONE_Q, c3b_pkg::ONE_Q);
    add_item(ACT_COLUMN, 3'd7, c3b_pkg::MAXV, c3b_pkg::MINV, c3b_pkg::MAXV,
             c3b_pkg::MINV, c3b_pkg::MAXV, c3b_pkg::MINV);
    // at the big primary, then at the small one
    add_item(ACT_STATE, 3'd0, 0, 0, 0, c3b_pkg::ONE_Q, -c3b_pkg::ONE_Q, 0);
    add_item(ACT_COLUMN, 3'd6, c3b_pkg::ONE_Q, 0, 0, 0, 0, 0);
    add_item(ACT_STATE, 3'd0, c3b_pkg::ONE_Q, 0, 0, 0, 0, 0);
    add_item(ACT_COLUMN, 3'd1, 0, c3b_pkg::ONE_Q, 0, 0, 0, 0);
    wait_drained();

    // mass ratio at its top, above one half
    write_mass_ratio(MU_MAX);
    add_item(ACT_STATE, 3'd0, -mu_q, 0, 0, 0, 0, 0);
    add_item(ACT_STATE, 3'd0, -mu_q + 1, 0, 1, 0, 0, 0);
    add_item(ACT_COLUMN, 3'd2, 1, 1, 1, 1, 1, 1);
    add_item(ACT_STATE, 3'd0, c3b_pkg::MAXV, c3b_pkg::MAXV, c3b_pkg::MAXV,
             c3b_pkg::MAXV, c3b_pkg::MAXV, c3b_pkg::MAXV);
    add_item(ACT_COLUMN, 3'd3, c3b_pkg::MINV, c3b_pkg::MINV, c3b_pkg::MINV,
             c3b_pkg::MINV, c3b_pkg::MINV, c3b_pkg::MINV);
    add_item(ACT_STATE, 3'd0, c3b_pkg::MINV, c3b_pkg::MINV, c3b_pkg::MINV,
             c3b_pkg::MINV, c3b_pkg::MINV, c3b_pkg::MINV);
    add_item(ACT_COLUMN, 3'd4, c3b_pkg::MAXV, c3b_pkg::MAXV, c3b_pkg::MAXV,
             c3b_pkg::MAXV, c3b_pkg::MAXV, c3b_pkg::MAXV);
    add_item(ACT_STATE, 3'd5, c3b_pkg::ONE_Q >>> 1, c3b_pkg::ONE_Q >>> 2,
             -(c3b_pkg::ONE_Q >>> 3), 3, -5, 7);
    add_item(ACT_COLUMN, 3'd5, -1, -1, -1, -1, -1, -1);
    wait_drained();

    // random phases, each with its own mass ratio
    mu_set = '{MU_HALF, MU_EM, 47'({$urandom, $urandom}), 47'd0, MU_MAX};
    for (int ph = 0; ph < 5; ph++) begin
      write_mass_ratio(mu_set[ph]);
      quiet = (ph == 3);
      // long receiver hold while the sender keeps offering words
      if (ph == 1) hold_req = 1'b1;
      n = 0;
      while (n < 360) begin
        if ($urandom_range(0, 9) < 7) begin
          add_sequence();
          n += 7;
        end else begin
          add_item(1'($urandom), 3'($urandom), rand_full(), rand_full(), rand_full(),
                   rand_full(), rand_full(), rand_full());
          n++;
        end
      end
      // sender pauses until every result is back
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
